// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/mapfl_pkg.sv =====
`timescale 1ns / 1ps

package mapfl_pkg;

	// sizing of the allocator
	localparam int AREA_COUNT     = 4;
	localparam int PAGES_PER_AREA = 1024;
	// page size, a power of two
	localparam int PAGE_BYTES     = 4096;

	// fixed field widths
	localparam int CFG_AREAS   = 4;
	localparam int ADDR_W      = 52;
	localparam int PAGES_REG_W = 11;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;

	// derived widths
	localparam int AREA_W     = (AREA_COUNT > 1) ? $clog2(AREA_COUNT) : 1;
	localparam int SLOT_W     = (PAGES_PER_AREA > 1) ? $clog2(PAGES_PER_AREA) : 1;
	localparam int COUNT_W    = $clog2(PAGES_PER_AREA + 1);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int RING_AW    = AREA_W + SLOT_W;
	localparam int RING_DEPTH = 1 << RING_AW;

	// apb register file
	localparam int PADDR_W   = 6;
	localparam int PDATA_W   = 64;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_AREA0_BASE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AREA1_BASE  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_AREA2_BASE  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_AREA3_BASE  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_AREA0_PAGES = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_AREA1_PAGES = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_AREA2_PAGES = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_AREA3_PAGES = 3'd7;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_PAGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

	// area configuration as seen by the controller
	typedef struct packed {
		logic [CFG_AREAS-1:0][ADDR_W-1:0]      base;
		logic [CFG_AREAS-1:0][PAGES_REG_W-1:0] pages;
	} area_cfg_t;

	// page count clipped to the ring size
	function automatic logic [COUNT_W-1:0] usable_pages(input logic [PAGES_REG_W-1:0] p);
		if (int'(p) > PAGES_PER_AREA)
			return COUNT_W'(PAGES_PER_AREA);
		else
			return COUNT_W'(p);
	endfunction

endpackage

// ===== rtl/mapfl_ram.sv =====
`timescale 1ns / 1ps

module mapfl_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 4096
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mapfl_regs.sv =====
`timescale 1ns / 1ps

module mapfl_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mapfl_pkg::PADDR_W-1:0]   paddr,
	input  logic [mapfl_pkg::PDATA_W-1:0]   pwdata,
	output logic [mapfl_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	output mapfl_pkg::area_cfg_t            cfg
);

	mapfl_pkg::area_cfg_t               cfg_q;
	logic [mapfl_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                               wr_en;

	assign reg_idx = paddr[mapfl_pkg::PADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				mapfl_pkg::REG_AREA0_BASE:  cfg_q.base[0]  <= pwdata[mapfl_pkg::ADDR_W-1:0];
				mapfl_pkg::REG_AREA1_BASE:  cfg_q.base[1]  <= pwdata[mapfl_pkg::ADDR_W-1:0];
				mapfl_pkg::REG_AREA2_BASE:  cfg_q.base[2]  <= pwdata[mapfl_pkg::ADDR_W-1:0];
				mapfl_pkg::REG_AREA3_BASE:  cfg_q.base[3]  <= pwdata[mapfl_pkg::ADDR_W-1:0];
				mapfl_pkg::REG_AREA0_PAGES: cfg_q.pages[0] <= pwdata[mapfl_pkg::PAGES_REG_W-1:0];
				mapfl_pkg::REG_AREA1_PAGES: cfg_q.pages[1] <= pwdata[mapfl_pkg::PAGES_REG_W-1:0];
				mapfl_pkg::REG_AREA2_PAGES: cfg_q.pages[2] <= pwdata[mapfl_pkg::PAGES_REG_W-1:0];
				mapfl_pkg::REG_AREA3_PAGES: cfg_q.pages[3] <= pwdata[mapfl_pkg::PAGES_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			mapfl_pkg::REG_AREA0_BASE:  prdata = mapfl_pkg::PDATA_W'(cfg_q.base[0]);
			mapfl_pkg::REG_AREA1_BASE:  prdata = mapfl_pkg::PDATA_W'(cfg_q.base[1]);
			mapfl_pkg::REG_AREA2_BASE:  prdata = mapfl_pkg::PDATA_W'(cfg_q.base[2]);
			mapfl_pkg::REG_AREA3_BASE:  prdata = mapfl_pkg::PDATA_W'(cfg_q.base[3]);
			mapfl_pkg::REG_AREA0_PAGES: prdata = mapfl_pkg::PDATA_W'(cfg_q.pages[0]);
			mapfl_pkg::REG_AREA1_PAGES: prdata = mapfl_pkg::PDATA_W'(cfg_q.pages[1]);
			mapfl_pkg::REG_AREA2_PAGES: prdata = mapfl_pkg::PDATA_W'(cfg_q.pages[2]);
			mapfl_pkg::REG_AREA3_PAGES: prdata = mapfl_pkg::PDATA_W'(cfg_q.pages[3]);
			default:                    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/mapfl_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mapfl_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [mapfl_pkg::CMD_W-1:0]       command,
	input  logic [mapfl_pkg::ADDR_W-1:0]      page_address,
	input  mapfl_pkg::area_cfg_t              cfg,
	output logic                              done,
	output logic [mapfl_pkg::STATUS_W-1:0]    status,
	output logic [mapfl_pkg::ADDR_W-1:0]      granted_address,
	output logic                              ram_we,
	output logic [mapfl_pkg::RING_AW-1:0]     ram_waddr,
	output logic [mapfl_pkg::SLOT_W-1:0]      ram_wdata,
	output logic                              ram_re,
	output logic [mapfl_pkg::RING_AW-1:0]     ram_raddr,
	input  logic [mapfl_pkg::SLOT_W-1:0]      ram_rdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_FREE  = 2'd2;
	localparam logic [1:0] ST_INIT  = 2'd3;

	logic [1:0]                            state_q;
	logic [mapfl_pkg::SLOT_W-1:0]          head_q  [mapfl_pkg::AREA_COUNT];
	logic [mapfl_pkg::SLOT_W-1:0]          tail_q  [mapfl_pkg::AREA_COUNT];
	logic [mapfl_pkg::COUNT_W-1:0]         count_q [mapfl_pkg::AREA_COUNT];
	logic [mapfl_pkg::COUNT_W-1:0]         n_pages [mapfl_pkg::AREA_COUNT];

	// request fields held for the working state
	logic                                  found_s1;
	logic [mapfl_pkg::AREA_W-1:0]          area_s1;
	logic [mapfl_pkg::ADDR_W-1:0]          addr_s1;
	logic [mapfl_pkg::AREA_COUNT-1:0]      hit_s1;

	// init sweep position
	logic [mapfl_pkg::AREA_W-1:0]          ia_q;
	logic [mapfl_pkg::SLOT_W-1:0]          is_q;

	logic                                  done_q;
	logic [mapfl_pkg::STATUS_W-1:0]        status_q;
	logic [mapfl_pkg::ADDR_W-1:0]          granted_q;

	logic                                  accept;
	logic                                  a_found;
	logic [mapfl_pkg::AREA_W-1:0]          a_sel;
	logic [mapfl_pkg::AREA_COUNT-1:0]      hit;
	logic                                  f_found;
	logic [mapfl_pkg::AREA_W-1:0]          f_sel;
	logic [mapfl_pkg::ADDR_W-1:0]          f_offset;
	logic [mapfl_pkg::SLOT_W-1:0]          f_index;
	logic                                  f_full;
	logic [mapfl_pkg::COUNT_W-1:0]         n_cur;
	logic                                  slot_last;
	logic                                  area_last;
	logic [mapfl_pkg::ADDR_W-1:0]          alloc_addr;
	logic [mapfl_pkg::STATUS_W-1:0]        res_status;
	logic [mapfl_pkg::ADDR_W-1:0]          res_granted;

	function automatic logic [mapfl_pkg::SLOT_W-1:0] next_slot(
		input logic [mapfl_pkg::SLOT_W-1:0] s
	);
		if (s == mapfl_pkg::SLOT_W'(mapfl_pkg::PAGES_PER_AREA - 1))
			return '0;
		else
			return s + mapfl_pkg::SLOT_W'(1);
	endfunction

	assign busy            = (state_q != ST_IDLE);
	assign accept          = start && !busy;
	assign done            = done_q;
	assign status          = status_q;
	assign granted_address = granted_q;

	// clipped page count per area
	always_comb begin
		for (int a = 0; a < mapfl_pkg::AREA_COUNT; a++)
			n_pages[a] = mapfl_pkg::usable_pages(cfg.pages[a]);
	end

	// first area with a free page
	always_comb begin
		a_found = 1'b0;
		a_sel   = '0;
		for (int a = mapfl_pkg::AREA_COUNT - 1; a >= 0; a--) begin
			if (count_q[a] != '0) begin
				a_found = 1'b1;
				a_sel   = mapfl_pkg::AREA_W'(a);
			end
		end
	end

	// range check of the freed address against each area
	always_comb begin
		logic [mapfl_pkg::ADDR_W:0] limit;
		for (int a = 0; a < mapfl_pkg::AREA_COUNT; a++) begin
			limit = {1'b0, cfg.base[a]}
				+ ((mapfl_pkg::ADDR_W + 1)'(n_pages[a]) << mapfl_pkg::PAGE_SHIFT);
			hit[a] = (page_address >= cfg.base[a]) && ({1'b0, page_address} < limit);
		end
	end

	// first matching area and page index for a free
	always_comb begin
		f_found = 1'b0;
		f_sel   = '0;
		for (int a = mapfl_pkg::AREA_COUNT - 1; a >= 0; a--) begin
			if (hit_s1[a]) begin
				f_found = 1'b1;
				f_sel   = mapfl_pkg::AREA_W'(a);
			end
		end
		f_offset = addr_s1 - cfg.base[f_sel];
		f_index  = f_offset[mapfl_pkg::PAGE_SHIFT +: mapfl_pkg::SLOT_W];
		f_full   = (count_q[f_sel] >= n_pages[f_sel]);
	end

	// init sweep bookkeeping
	assign n_cur     = n_pages[ia_q];
	assign slot_last = ((mapfl_pkg::COUNT_W'(is_q) + mapfl_pkg::COUNT_W'(1)) == n_cur)
		|| (n_cur == '0);
	assign area_last = (ia_q == mapfl_pkg::AREA_W'(mapfl_pkg::AREA_COUNT - 1));

	// granted address from the ring entry
	assign alloc_addr = cfg.base[area_s1]
		+ (mapfl_pkg::ADDR_W'(ram_rdata) << mapfl_pkg::PAGE_SHIFT);

	// ring memory access
	always_comb begin
		ram_re    = accept && (command == mapfl_pkg::CMD_ALLOC) && a_found;
		ram_raddr = {a_sel, head_q[a_sel]};
		ram_we    = 1'b0;
		ram_waddr = {ia_q, is_q};
		ram_wdata = is_q;
		case (state_q)
			ST_FREE: begin
				ram_we    = f_found && !f_full;
				ram_waddr = {f_sel, tail_q[f_sel]};
				ram_wdata = f_index;
			end
			ST_INIT: begin
				ram_we = (n_cur != '0);
			end
			default: ;
		endcase
	end

	// result of the request finishing this cycle
	always_comb begin
		res_status  = mapfl_pkg::STAT_OK;
		res_granted = '0;
		case (state_q)
			ST_ALLOC: begin
				res_status  = found_s1 ? mapfl_pkg::STAT_OK : mapfl_pkg::STAT_NO_PAGE;
				res_granted = found_s1 ? alloc_addr : '0;
			end
			ST_FREE: begin
				if (!f_found)
					res_status = mapfl_pkg::STAT_OUTSIDE;
				else if (f_full)
					res_status = mapfl_pkg::STAT_FULL;
			end
			default: ;
		endcase
	end

	// sequencer and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			ia_q    <= '0;
			is_q    <= '0;
			for (int a = 0; a < mapfl_pkg::AREA_COUNT; a++) begin
				head_q[a]  <= '0;
				tail_q[a]  <= '0;
				count_q[a] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (command)
							mapfl_pkg::CMD_ALLOC: begin
								if (a_found) begin
									head_q[a_sel]  <= next_slot(head_q[a_sel]);
									count_q[a_sel] <= count_q[a_sel] - mapfl_pkg::COUNT_W'(1);
								end
								state_q <= ST_ALLOC;
							end
							mapfl_pkg::CMD_FREE: begin
								state_q <= ST_FREE;
							end
							mapfl_pkg::CMD_INIT: begin
								for (int a = 0; a < mapfl_pkg::AREA_COUNT; a++) begin
									head_q[a]  <= '0;
									count_q[a] <= n_pages[a];
									if (n_pages[a] == mapfl_pkg::COUNT_W'(mapfl_pkg::PAGES_PER_AREA))
										tail_q[a] <= '0;
									else
										tail_q[a] <= mapfl_pkg::SLOT_W'(n_pages[a]);
								end
								ia_q    <= '0;
								is_q    <= '0;
								state_q <= ST_INIT;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_ALLOC: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FREE: begin
					if (f_found && !f_full) begin
						tail_q[f_sel]  <= next_slot(tail_q[f_sel]);
						count_q[f_sel] <= count_q[f_sel] + mapfl_pkg::COUNT_W'(1);
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_INIT: begin
					if (slot_last) begin
						is_q <= '0;
						if (area_last) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							ia_q <= ia_q + mapfl_pkg::AREA_W'(1);
						end
					end else begin
						is_q <= is_q + mapfl_pkg::SLOT_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request payload and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			found_s1 <= a_found;
			area_s1  <= a_sel;
			addr_s1  <= page_address;
			hit_s1   <= hit;
		end
		status_q  <= res_status;
		granted_q <= res_granted;
	end

	`ASSERT_PROP(a_done_after_work, clk, arst_n, done_q |-> $past(state_q != ST_IDLE || (start && command == mapfl_pkg::CMD_NOP)), "result strobe without a request")
	`ASSERT_NEVER(a_no_write_on_alloc, clk, arst_n, ram_we && (state_q == ST_IDLE || state_q == ST_ALLOC), "ring written outside free or init")
	`ASSERT_PROP(a_alloc_enters, clk, arst_n, (accept && command == mapfl_pkg::CMD_ALLOC) |=> (state_q == ST_ALLOC), "allocate request lost")
	`ASSERT_PROP(a_count_bound, clk, arst_n, count_q[0] <= mapfl_pkg::COUNT_W'(mapfl_pkg::PAGES_PER_AREA), "free count above ring size")

endmodule

// ===== rtl/multi_area_page_free_list_allocator_top.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake             | payload
// request   | in        | start, busy           | command, page_address
// result    | out       | done (one-cycle)      | status, granted_address
// config    | in/out    | apb psel/penable, rdy | paddr, pwdata, prdata
//
// allocate and free each run from the accept cycle into a working state that uses the ring
// memory read data (allocate) or does the ring write and pointer update (free). init sweeps
// the areas in order, one ring write per cycle; an area without pages writes nothing.
// the result shows on the outputs for one cycle after the last working cycle;
// a new request can be accepted in that same cycle. the receiver cannot stall.
// reset clears the sequencer, pointers, counts and config at once; the ring memory needs no clearing pass.

module multi_area_page_free_list_allocator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [mapfl_pkg::CMD_W-1:0]       command,
	input  logic [mapfl_pkg::ADDR_W-1:0]      page_address,
	output logic                              done,
	output logic [mapfl_pkg::STATUS_W-1:0]    status,
	output logic [mapfl_pkg::ADDR_W-1:0]      granted_address,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mapfl_pkg::PADDR_W-1:0]     paddr,
	input  logic [mapfl_pkg::PDATA_W-1:0]     pwdata,
	output logic [mapfl_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);

	mapfl_pkg::area_cfg_t                  cfg;
	logic                                  ram_we;
	logic [mapfl_pkg::RING_AW-1:0]         ram_waddr;
	logic [mapfl_pkg::SLOT_W-1:0]          ram_wdata;
	logic                                  ram_re;
	logic [mapfl_pkg::RING_AW-1:0]         ram_raddr;
	logic [mapfl_pkg::SLOT_W-1:0]          ram_rdata;

	// area configuration registers
	mapfl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// free list rings of all areas
	mapfl_ram #(
		.WIDTH (mapfl_pkg::SLOT_W),
		.DEPTH (mapfl_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// request sequencer with ring pointers
	mapfl_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.page_address    (page_address),
		.cfg             (cfg),
		.done            (done),
		.status          (status),
		.granted_address (granted_address),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata)
	);

endmodule

// ===== sim/multi_area_page_free_list_allocator_top_test.sv =====
`timescale 1ns / 1ps

module multi_area_page_free_list_allocator_top_test;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [63:0] ADDR_MASK64 = (64'd1 << mapfl_pkg::ADDR_W) - 64'd1;
	localparam logic [63:0] PAGES_MASK64 = (64'd1 << mapfl_pkg::PAGES_REG_W) - 64'd1;
	localparam logic [mapfl_pkg::ADDR_W-1:0] TOP_ADDR = {mapfl_pkg::ADDR_W{1'b1}};

	typedef struct packed {
		logic [mapfl_pkg::STATUS_W-1:0] status;
		logic [mapfl_pkg::ADDR_W-1:0]   granted;
	} grant_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [mapfl_pkg::CMD_W-1:0]    command;
	logic [mapfl_pkg::ADDR_W-1:0]   page_address;
	logic                           done;
	logic [mapfl_pkg::STATUS_W-1:0] status;
	logic [mapfl_pkg::ADDR_W-1:0]   granted_address;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [mapfl_pkg::PADDR_W-1:0]  paddr;
	logic [mapfl_pkg::PDATA_W-1:0]  pwdata;
	logic [mapfl_pkg::PDATA_W-1:0]  prdata;
	logic                           pready;

	// allocator state as predicted
	logic [mapfl_pkg::ADDR_W-1:0]      area_base_q [mapfl_pkg::AREA_COUNT];
	logic [mapfl_pkg::PAGES_REG_W-1:0] area_pages_q [mapfl_pkg::AREA_COUNT];
	logic [mapfl_pkg::SLOT_W-1:0]
		page_ring [mapfl_pkg::AREA_COUNT][mapfl_pkg::PAGES_PER_AREA];
	int                                ring_rd [mapfl_pkg::AREA_COUNT];
	int                                ring_wr [mapfl_pkg::AREA_COUNT];
	int                                pages_free [mapfl_pkg::AREA_COUNT];

	grant_t                       expected_grants[$];
	logic [mapfl_pkg::ADDR_W-1:0] granted_pool[$];
	grant_t                       oldest_grant;
	int                           mismatches;
	int                           idle_cycles;
	int                           idle_pct;

	multi_area_page_free_list_allocator_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.page_address    (page_address),
		.done            (done),
		.status          (status),
		.granted_address (granted_address),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// page count after clipping to the ring size
	function automatic int area_usable(input int a);
		if (int'(area_pages_q[a]) > mapfl_pkg::PAGES_PER_AREA)
			return mapfl_pkg::PAGES_PER_AREA;
		return int'(area_pages_q[a]);
	endfunction

	// one request against the predicted lists, returns the expected result
	function automatic grant_t allocator_step(input logic [mapfl_pkg::CMD_W-1:0] cmd,
			input logic [mapfl_pkg::ADDR_W-1:0] addr);
		grant_t g;
		logic   found;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] sum;
		logic [63:0] idx;
		int n;
		g.status = mapfl_pkg::STAT_OK;
		g.granted = '0;
		found = 1'b0;
		case (cmd)
			mapfl_pkg::CMD_ALLOC: begin
				g.status = mapfl_pkg::STAT_NO_PAGE;
				for (int a = 0; a < mapfl_pkg::AREA_COUNT; a++) begin
					if (!found && pages_free[a] != 0) begin
						found = 1'b1;
						sum = {12'b0, area_base_q[a]}
							+ 64'(page_ring[a][ring_rd[a]]) * mapfl_pkg::PAGE_BYTES;
						g.granted = sum[mapfl_pkg::ADDR_W-1:0];
						g.status = mapfl_pkg::STAT_OK;
						ring_rd[a] = (ring_rd[a] + 1) % mapfl_pkg::PAGES_PER_AREA;
						pages_free[a]--;
					end
				end
			end
			mapfl_pkg::CMD_FREE: begin
				g.status = mapfl_pkg::STAT_OUTSIDE;
				for (int a = 0; a < mapfl_pkg::AREA_COUNT; a++) begin
					n = area_usable(a);
					lo = {12'b0, area_base_q[a]};
					hi = lo + 64'(n) * mapfl_pkg::PAGE_BYTES;
					if (!found && {12'b0, addr} >= lo && {12'b0, addr} < hi) begin
						found = 1'b1;
						if (pages_free[a] >= n) begin
							g.status = mapfl_pkg::STAT_FULL;
						end else begin
							idx = ({12'b0, addr} - lo) / mapfl_pkg::PAGE_BYTES;
							page_ring[a][ring_wr[a]] = idx[mapfl_pkg::SLOT_W-1:0];
							ring_wr[a] = (ring_wr[a] + 1) % mapfl_pkg::PAGES_PER_AREA;
							pages_free[a]++;
							g.status = mapfl_pkg::STAT_OK;
						end
					end
				end
			end
			mapfl_pkg::CMD_INIT: begin
				for (int a = 0; a < mapfl_pkg::AREA_COUNT; a++) begin
					n = area_usable(a);
					for (int i = 0; i < n; i++)
						page_ring[a][i] = mapfl_pkg::SLOT_W'(i);
					ring_rd[a] = 0;
					ring_wr[a] = n % mapfl_pkg::PAGES_PER_AREA;
					pages_free[a] = n;
				end
			end
			default: begin
			end
		endcase
		return g;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %h, got %h", what, want, got);
	endtask

	// result checking and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
			if (done) begin
				if (expected_grants.size() == 0) begin
					note_mismatch("unexpected result", 64'd0,
						64'({status, granted_address}));
				end else begin
					oldest_grant = expected_grants.pop_front();
					if (status !== oldest_grant.status)
						note_mismatch("status", 64'(oldest_grant.status), 64'(status));
					if (granted_address !== oldest_grant.granted)
						note_mismatch("granted_address", 64'(oldest_grant.granted),
							64'(granted_address));
				end
			end
		end
	end

	function automatic logic [mapfl_pkg::ADDR_W-1:0] random_address();
		return mapfl_pkg::ADDR_W'({$urandom, $urandom});
	endfunction

	// drive one request and predict its result once accepted
	task automatic send_request(input logic [mapfl_pkg::CMD_W-1:0] cmd,
			input logic [mapfl_pkg::ADDR_W-1:0] addr);
		grant_t g;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		page_address <= addr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		g = allocator_step(cmd, addr);
		expected_grants.push_back(g);
		if (cmd == mapfl_pkg::CMD_ALLOC && g.status == mapfl_pkg::STAT_OK) begin
			granted_pool.push_back(g.granted);
			if (granted_pool.size() > 64)
				void'(granted_pool.pop_front());
		end
	endtask

	// drop start and let every outstanding request finish
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (expected_grants.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write followed by a read back of the stored value
	task automatic cfg_write(input logic [mapfl_pkg::REG_IDX_W-1:0] idx,
			input logic [63:0] value);
		logic [63:0] stored;
		if (idx < mapfl_pkg::REG_AREA0_PAGES)
			stored = value & ADDR_MASK64;
		else
			stored = value & PAGES_MASK64;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= mapfl_pkg::PADDR_W'({idx, 3'b000});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx < mapfl_pkg::REG_AREA0_PAGES)
			area_base_q[idx] = stored[mapfl_pkg::ADDR_W-1:0];
		else
			area_pages_q[idx - mapfl_pkg::REG_AREA0_PAGES] =
				stored[mapfl_pkg::PAGES_REG_W-1:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== stored)
			note_mismatch("register read", stored, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_area(input int a, input logic [mapfl_pkg::ADDR_W-1:0] base,
			input logic [mapfl_pkg::PAGES_REG_W-1:0] pages);
		cfg_write(mapfl_pkg::REG_AREA0_BASE + mapfl_pkg::REG_IDX_W'(a),
			{$urandom, $urandom} & ~ADDR_MASK64 | 64'(base));
		cfg_write(mapfl_pkg::REG_AREA0_PAGES + mapfl_pkg::REG_IDX_W'(a),
			{$urandom, $urandom} & ~PAGES_MASK64 | 64'(pages));
	endtask

	// empty lists after reset, all areas disabled
	task automatic test_reset_state();
		idle_pct = 0;
		send_request(mapfl_pkg::CMD_ALLOC, '0);
		send_request(mapfl_pkg::CMD_FREE, '0);
		send_request(mapfl_pkg::CMD_NOP, TOP_ADDR);
		send_request(mapfl_pkg::CMD_INIT, TOP_ADDR);
		send_request(mapfl_pkg::CMD_ALLOC, random_address());
		wait_idle();
	endtask

	// field extremes, wrap, bounds, full list, double free, late register change
	task automatic test_special_cases();
		idle_pct = 0;
		set_area(0, 52'h0_0000_0000_1000, 11'd3);
		set_area(1, 52'hF_FFFF_FFFF_F000, 11'd2);
		set_area(2, 52'h0_0000_0001_2345, 11'd5);
		set_area(3, 52'h0_0000_0800_0000, 11'd2047);
		send_request(mapfl_pkg::CMD_INIT, '0);
		repeat (3) send_request(mapfl_pkg::CMD_ALLOC, '0);
		// second page of the top area wraps to zero
		repeat (2) send_request(mapfl_pkg::CMD_ALLOC, TOP_ADDR);
		// unaligned base
		send_request(mapfl_pkg::CMD_ALLOC, '0);
		// offset bits dropped
		send_request(mapfl_pkg::CMD_FREE, 52'h0_0000_0000_3FFF);
		// same page twice, then the list is full
		send_request(mapfl_pkg::CMD_FREE, 52'h0_0000_0000_1000);
		send_request(mapfl_pkg::CMD_FREE, 52'h0_0000_0000_1000);
		send_request(mapfl_pkg::CMD_FREE, 52'h0_0000_0000_2000);
		send_request(mapfl_pkg::CMD_FREE, TOP_ADDR);
		// below every area, past the upper bound, just below a base
		send_request(mapfl_pkg::CMD_FREE, '0);
		send_request(mapfl_pkg::CMD_FREE, 52'h0_0000_0001_2345 + 52'h5000);
		send_request(mapfl_pkg::CMD_FREE, 52'h0_0000_0001_2344);
		send_request(mapfl_pkg::CMD_NOP, TOP_ADDR);
		// clipped count, list already full
		send_request(mapfl_pkg::CMD_FREE, 52'h0_0000_0800_0000 + 52'h3F_F000);
		wait_idle();
		// base moved after init, stored indices reused
		cfg_write(mapfl_pkg::REG_AREA0_BASE, 64'h0000_0000_0004_0000);
		send_request(mapfl_pkg::CMD_ALLOC, '0);
		send_request(mapfl_pkg::CMD_ALLOC, '0);
		wait_idle();
		// disabled area keeps its queued page
		cfg_write(mapfl_pkg::REG_AREA0_PAGES, 64'd0);
		send_request(mapfl_pkg::CMD_FREE, 52'h0_0000_0004_0000);
		send_request(mapfl_pkg::CMD_ALLOC, '0);
		wait_idle();
	endtask

	// new base and size for every area, mostly small and packed together
	task automatic randomize_areas();
		logic [63:0] cursor;
		logic [63:0] b;
		int p;
		int pick;
		cursor = {$urandom, $urandom} & ADDR_MASK64 & ~64'hFFF;
		for (int a = 0; a < mapfl_pkg::AREA_COUNT; a++) begin
			pick = $urandom_range(0, 9);
			case (pick)
				6: b = {$urandom, $urandom};
				7: b = {12'b0, TOP_ADDR}
					- 64'($urandom_range(0, 20)) * mapfl_pkg::PAGE_BYTES;
				8: b = cursor + 64'($urandom_range(0, mapfl_pkg::PAGE_BYTES - 1));
				9: b = cursor - 64'($urandom_range(0, 2)) * mapfl_pkg::PAGE_BYTES;
				default: b = cursor + 64'($urandom_range(0, 3)) * mapfl_pkg::PAGE_BYTES;
			endcase
			b = b & ADDR_MASK64;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				p = 0;
			else if (pick < 92)
				p = $urandom_range(1, 12);
			else
				p = $urandom_range(1000, 2047);
			set_area(a, b[mapfl_pkg::ADDR_W-1:0], mapfl_pkg::PAGES_REG_W'(p));
			cursor = (b + 64'(p) * mapfl_pkg::PAGE_BYTES) & ADDR_MASK64;
		end
	endtask

	// free address: a granted page, a spot near an area, or noise
	function automatic logic [mapfl_pkg::ADDR_W-1:0] free_target();
		logic [mapfl_pkg::ADDR_W-1:0] addr;
		logic [63:0] near;
		int k;
		int pick;
		int a;
		pick = $urandom_range(0, 99);
		if (pick < 55 && granted_pool.size() != 0) begin
			k = $urandom_range(0, granted_pool.size() - 1);
			addr = granted_pool[k];
			granted_pool.delete(k);
			if ($urandom_range(0, 3) == 0)
				addr[mapfl_pkg::PAGE_SHIFT-1:0] = mapfl_pkg::PAGE_SHIFT'($urandom);
		end else if (pick < 88) begin
			a = $urandom_range(0, mapfl_pkg::AREA_COUNT - 1);
			near = {12'b0, area_base_q[a]}
				+ 64'($urandom_range(0, area_usable(a) * mapfl_pkg::PAGE_BYTES
					+ 2 * mapfl_pkg::PAGE_BYTES))
				- 64'(mapfl_pkg::PAGE_BYTES);
			addr = near[mapfl_pkg::ADDR_W-1:0];
		end else begin
			addr = random_address();
		end
		return addr;
	endfunction

	task automatic run_random_phase(input int pct, input int count);
		int pick;
		idle_pct = 0;
		wait_idle();
		randomize_areas();
		idle_pct = pct;
		if ($urandom_range(0, 4) != 0)
			send_request(mapfl_pkg::CMD_INIT, random_address());
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 46)
				send_request(mapfl_pkg::CMD_ALLOC, random_address());
			else if (pick < 93)
				send_request(mapfl_pkg::CMD_FREE, free_target());
			else if (pick < 97)
				send_request(mapfl_pkg::CMD_INIT, random_address());
			else
				send_request(mapfl_pkg::CMD_NOP, random_address());
		end
		wait_idle();
	endtask

	// random traffic under each sender idling mode
	task automatic test_random_traffic();
		run_random_phase(0, 290);
		run_random_phase(57, 290);
		run_random_phase(7, 290);
		run_random_phase(0, 290);
		run_random_phase(57, 290);
		run_random_phase(7, 290);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = mapfl_pkg::CMD_NOP;
		page_address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		idle_cycles = 0;
		idle_pct = 0;
		for (int a = 0; a < mapfl_pkg::AREA_COUNT; a++) begin
			area_base_q[a] = '0;
			area_pages_q[a] = '0;
			ring_rd[a] = 0;
			ring_wr[a] = 0;
			pages_free[a] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_special_cases();
		test_random_traffic();

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_grants.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
